@@ hw/rtl/perm_unrk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package perm_unrk_pkg;

  localparam int MAX_SIZE = 16;
  localparam int RANK_W   = 45;
  localparam int SIZE_W   = 5;
  localparam int ELEM_W   = 4;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int DIGIT_W  = 4;
  // quotient bits are found MSB first, one per cycle
  localparam int SHIFT_W  = RANK_W + DIGIT_W - 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

  // k! for k = 0 .. MAX_SIZE
  localparam logic [RANK_W-1:0] FACT [0:MAX_SIZE] = '{
    45'd1, 45'd1, 45'd2, 45'd6, 45'd24, 45'd120, 45'd720, 45'd5040,
    45'd40320, 45'd362880, 45'd3628800, 45'd39916800, 45'd479001600,
    45'd6227020800, 45'd87178291200, 45'd1307674368000,
    45'd20922789888000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/permutation_unrank_unit.sv @@
// Lexicographic permutation unranker. Each rank request is decoded into the
// permutation of 0 .. n-1 with that rank, n being perm_size clamped to
// 2 .. 16; the elements leave one result each, first position first, with
// last on the final one. A rank of n! or more gives a single result with
// rank_error and last set and element 0. Flow: a request is taken only
// while the unit is idle and is then range-checked; each element is then
// produced in steps (one to load the divider, four compare-subtract steps
// of the shared digit divider, one to pick up the digit, one to emit), and
// an emit waits while the receiver holds off the previous element; a
// rejected rank goes straight from the check to its emit. The output
// register lets the next request in while the final result still waits.
`timescale 1ns / 1ps
`default_nettype none

module permutation_unrank_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [perm_unrk_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                                rank_valid,
  output logic                                     rank_ready,
  input  wire logic [perm_unrk_pkg::RANK_W-1:0]    rank,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic [perm_unrk_pkg::ELEM_W-1:0]         element,
  output logic                                     last,
  output logic                                     rank_error
);

  perm_unrk_pkg::state_t state, state_next;

  logic [perm_unrk_pkg::SIZE_W-1:0]  perm_size;
  logic [perm_unrk_pkg::SIZE_W-1:0]  size_eff;
  logic [perm_unrk_pkg::SIZE_W-1:0]  remaining;   // unused values left
  logic [perm_unrk_pkg::RANK_W-1:0]  rem_rank;    // rank still to decode
  logic [perm_unrk_pkg::IDX_W-1:0]   digit;
  logic [perm_unrk_pkg::IDX_W-1:0]   pool [perm_unrk_pkg::MAX_SIZE];
  logic                              err;
  logic                              too_big;
  logic                              out_free;
  logic                              load_out;
  logic                              div_start;
  logic                              div_done;
  logic [perm_unrk_pkg::DIGIT_W-1:0] div_quo;
  logic [perm_unrk_pkg::RANK_W-1:0]  div_rem;
  logic [perm_unrk_pkg::RANK_W-1:0]  div_divisor;

  assign cfg_ready = 1'b1;

  // register keeps what was written; clamp on use
  always_comb begin
    if (perm_size < perm_unrk_pkg::SIZE_MIN) begin
      size_eff = perm_unrk_pkg::SIZE_MIN;
    end else if (perm_size > perm_unrk_pkg::SIZE_MAX) begin
      size_eff = perm_unrk_pkg::SIZE_MAX;
    end else begin
      size_eff = perm_size;
    end
  end

  assign too_big     = rem_rank >= perm_unrk_pkg::FACT[remaining];
  assign div_divisor = perm_unrk_pkg::FACT[remaining - perm_unrk_pkg::SIZE_W'(1)];
  assign out_free    = !result_valid || result_ready;

  perm_unrk_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem_rank),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= perm_unrk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rank_ready = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      perm_unrk_pkg::ST_IDLE: begin
        rank_ready = 1'b1;
        if (rank_valid) begin
          state_next = perm_unrk_pkg::ST_CHECK;
        end
      end
      perm_unrk_pkg::ST_CHECK: begin
        state_next = too_big ? perm_unrk_pkg::ST_EMIT : perm_unrk_pkg::ST_START;
      end
      perm_unrk_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = perm_unrk_pkg::ST_DIV;
      end
      perm_unrk_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = perm_unrk_pkg::ST_EMIT;
        end
      end
      perm_unrk_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (err || remaining == perm_unrk_pkg::SIZE_W'(1)) begin
            state_next = perm_unrk_pkg::ST_IDLE;
          end else begin
            state_next = perm_unrk_pkg::ST_START;
          end
        end
      end
      default: begin
        state_next = perm_unrk_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size    <= perm_unrk_pkg::SIZE_RESET;
      result_valid <= 1'b0;
      err          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        perm_size <= cfg_data;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (rank_valid && rank_ready) begin
        err <= 1'b0;
      end else if (state == perm_unrk_pkg::ST_CHECK) begin
        err <= too_big;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rank_valid && rank_ready) begin
      rem_rank  <= rank;
      remaining <= size_eff;
      for (int i = 0; i < perm_unrk_pkg::MAX_SIZE; i++) begin
        pool[i] <= perm_unrk_pkg::IDX_W'(i);
      end
    end else if (state == perm_unrk_pkg::ST_DIV && div_done) begin
      rem_rank <= div_rem;
      // digit never reaches remaining for an in-range rank; clamp anyway
      if ({1'b0, div_quo} >= remaining) begin
        digit <= perm_unrk_pkg::IDX_W'(remaining - perm_unrk_pkg::SIZE_W'(1));
      end else begin
        digit <= perm_unrk_pkg::IDX_W'(div_quo);
      end
    end else if (load_out && !err) begin
      // drop the chosen value: everything above it moves down one place
      for (int i = 0; i < perm_unrk_pkg::MAX_SIZE - 1; i++) begin
        if (perm_unrk_pkg::IDX_W'(i) >= digit) begin
          pool[i] <= pool[i + 1];
        end
      end
      remaining <= remaining - perm_unrk_pkg::SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      element    <= err ? '0 : perm_unrk_pkg::ELEM_W'(pool[digit]);
      last       <= err || (remaining == perm_unrk_pkg::SIZE_W'(1));
      rank_error <= err;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && rank_error) |-> (last && element == '0))
    else $error("rank error result not a lone zero element");

  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    (state == perm_unrk_pkg::ST_EMIT && !err) |-> (remaining != '0))
    else $error("emitting with no values left");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == perm_unrk_pkg::ST_DIV))
    else $error("divider finished outside divide state");

  a_load_wait: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ hw/rtl/perm_unrk_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for one factorial digit: one compare-subtract per cycle.
module perm_unrk_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [perm_unrk_pkg::RANK_W-1:0]    dividend,
  input  wire logic [perm_unrk_pkg::RANK_W-1:0]    divisor,
  output logic                                     done,
  output logic [perm_unrk_pkg::DIGIT_W-1:0]        quotient,
  output logic [perm_unrk_pkg::RANK_W-1:0]         remainder
);

  localparam int CNT_W = $clog2(perm_unrk_pkg::DIGIT_W);

  logic                               busy;
  logic [CNT_W-1:0]                   cnt;
  logic [perm_unrk_pkg::RANK_W-1:0]   dvs;
  logic [perm_unrk_pkg::SHIFT_W-1:0]  shifted;
  logic [perm_unrk_pkg::SHIFT_W:0]    diff;

  assign shifted = perm_unrk_pkg::SHIFT_W'(dvs) << cnt;
  assign diff    = {1'b0, perm_unrk_pkg::SHIFT_W'(remainder)} - {1'b0, shifted};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(perm_unrk_pkg::DIGIT_W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= dividend;
      dvs       <= divisor;
      quotient  <= '0;
    end else if (busy && !diff[perm_unrk_pkg::SHIFT_W]) begin
      remainder     <= diff[perm_unrk_pkg::RANK_W-1:0];
      quotient[cnt] <= 1'b1;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted mid-division");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dvs))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Cycles without any handshake on any channel before the run is abandoned.
  // The slowest request (size 16) and the receiver stalls on top of it stay
  // well inside this, so it leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 5000;
  // Settling time after the final result.
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned RAND_PER_PHASE = 113;

  typedef struct packed {
    logic [perm_unrk_pkg::ELEM_W-1:0] element;
    logic                             last;
    logic                             rank_error;
  } perm_elem_t;

  // Scoreboard: holds its own copy of perm_size, turns every accepted rank
  // into the elements it should decode to, and checks results in order.
  class perm_scoreboard;
    logic [perm_unrk_pkg::SIZE_W-1:0] size_reg;
    perm_elem_t        pending[$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       ranks_noted;
    int unsigned       ranks_rejected;

    function new();
      size_reg        = perm_unrk_pkg::SIZE_RESET;
      mismatches      = 0;
      results_checked = 0;
      ranks_noted     = 0;
      ranks_rejected  = 0;
    endfunction

    // size actually used: register clamped into 2 .. MAX_SIZE
    function int clamp_size();
      if (size_reg < perm_unrk_pkg::SIZE_MIN) return int'(perm_unrk_pkg::SIZE_MIN);
      if (size_reg > perm_unrk_pkg::SIZE_MAX) return perm_unrk_pkg::MAX_SIZE;
      return int'(size_reg);
    endfunction

    function longint unsigned factorial(int k);
      longint unsigned f;
      f = 1;
      for (int i = 2; i <= k; i++) f = f * longint'(i);
      return f;
    endfunction

    // append one expected element at the tail of the queue
    function void add_expected(perm_elem_t x);
      pending = {pending, x};
    endfunction

    function void note_rank(logic [perm_unrk_pkg::RANK_W-1:0] r);
      int                               n;
      int                               remaining;
      int                               d;
      longint unsigned                  rem;
      longint unsigned                  w;
      longint unsigned                  digit;
      logic [perm_unrk_pkg::ELEM_W-1:0] pool [perm_unrk_pkg::MAX_SIZE];
      perm_elem_t                       item;
      n   = clamp_size();
      rem = longint'(r);
      ranks_noted++;
      if (rem >= factorial(n)) begin
        // out of range: one flagged result, element 0
        item            = '0;
        item.last       = 1'b1;
        item.rank_error = 1'b1;
        add_expected(item);
        ranks_rejected++;
        return;
      end
      for (int i = 0; i < n; i++) pool[i] = perm_unrk_pkg::ELEM_W'(i);
      remaining = n;
      for (int p = 0; p < n; p++) begin
        w     = factorial(remaining - 1);
        digit = rem / w;
        if (digit >= longint'(remaining)) digit = longint'(remaining - 1);
        d   = int'(digit);
        rem = rem - digit * w;
        item.element    = pool[d];
        item.last       = (p == n - 1);
        item.rank_error = 1'b0;
        add_expected(item);
        // drop the chosen value from the unused pool
        for (int i = d; i + 1 < remaining; i++) pool[i] = pool[i + 1];
        remaining--;
      end
    endfunction

    function void check_result(logic [perm_unrk_pkg::ELEM_W-1:0] e, logic l, logic er);
      perm_elem_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result element=%0d last=%0b rank_error=%0b",
                 $time, e, l, er);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      results_checked++;
      if (e !== want.element) begin
        $display("%0t: element expected %0d actual %0d", $time, want.element, e);
        mismatches++;
      end
      if (l !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, l);
        mismatches++;
      end
      if (er !== want.rank_error) begin
        $display("%0t: rank_error expected %0b actual %0b", $time, want.rank_error, er);
        mismatches++;
      end
    endfunction
  endclass

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             cfg_valid    = 1'b0;
  logic                             cfg_ready;
  logic [perm_unrk_pkg::SIZE_W-1:0] cfg_data     = '0;
  logic                             rank_valid   = 1'b0;
  logic                             rank_ready;
  logic [perm_unrk_pkg::RANK_W-1:0] rank         = '0;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic [perm_unrk_pkg::ELEM_W-1:0] element;
  logic                             last;
  logic                             rank_error;

  perm_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    idle_cycles   = 0;
  int unsigned    sizes_written = 0;

  permutation_unrank_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .rank_valid   (rank_valid),
    .rank_ready   (rank_ready),
    .rank         (rank),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .element      (element),
    .last         (last),
    .rank_error   (rank_error)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, random per cycle at the current phase's rate
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor: pre-edge values are sampled, so ordering in the step
  // does not matter
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(element, last, rank_error);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (rank_valid && rank_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // One rank request. Optional idle cycles first, then valid held with the
  // payload steady until taken. Valid is left high so back-to-back requests
  // never drop it within the step.
  task automatic send_rank(input logic [perm_unrk_pkg::RANK_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      rank_valid <= 1'b0;
      @(posedge clk);
    end
    rank_valid <= 1'b1;
    rank       <= v;
    do @(posedge clk); while (!rank_ready);
    sb.note_rank(v);
  endtask

  // Stop requesting and hold off until every expected element has arrived.
  task automatic drain;
    rank_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // perm_size write; only called with the unit idle
  task automatic write_size(input logic [perm_unrk_pkg::SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.size_reg = v;
    sizes_written++;
  endtask

  // Mostly small sizes to keep the run short, some large, some outside 2..16
  function automatic logic [perm_unrk_pkg::SIZE_W-1:0] pick_size();
    int unsigned roll;
    int unsigned r;
    roll = $urandom_range(99);
    if (roll < 55) return perm_unrk_pkg::SIZE_W'($urandom_range(2, 6));
    if (roll < 75) return perm_unrk_pkg::SIZE_W'($urandom_range(7, 10));
    if (roll < 87) return perm_unrk_pkg::SIZE_W'($urandom_range(11, 16));
    r = $urandom_range(16);
    return (r < 2) ? perm_unrk_pkg::SIZE_W'(r) : perm_unrk_pkg::SIZE_W'(r + 15);
  endfunction

  // Ranks: mostly in range, weighted toward both ends; some out of range,
  // either just past n! or across the full 45-bit field.
  function automatic logic [perm_unrk_pkg::RANK_W-1:0] pick_rank();
    int unsigned     roll;
    longint unsigned f;
    longint unsigned raw;
    f    = sb.factorial(sb.clamp_size());
    raw  = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 8)  return perm_unrk_pkg::RANK_W'(raw);
    if (roll < 12) return perm_unrk_pkg::RANK_W'(f + longint'($urandom_range(3)));
    if (roll < 18) begin
      return perm_unrk_pkg::RANK_W'(f - 1 - (longint'($urandom_range(3)) % f));
    end
    if (roll < 22) return perm_unrk_pkg::RANK_W'(longint'($urandom_range(3)) % f);
    return perm_unrk_pkg::RANK_W'(raw % f);
  endfunction

  initial begin
    longint unsigned f16;
    int unsigned     sent;
    int unsigned     burst;
    sb  = new();
    f16 = sb.factorial(perm_unrk_pkg::MAX_SIZE);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed requests, first idling profile ---
    send_idle_pct = 9;
    recv_idle_pct = 57;

    // reset size 8: both ends of the range, just past it, all ones, one in between
    send_rank('0);
    send_rank(perm_unrk_pkg::RANK_W'(40319));
    send_rank(perm_unrk_pkg::RANK_W'(40320));
    send_rank('1);
    send_rank(perm_unrk_pkg::RANK_W'(12345));
    drain;

    // smallest size
    write_size(perm_unrk_pkg::SIZE_MIN);
    send_rank(perm_unrk_pkg::RANK_W'(0));
    send_rank(perm_unrk_pkg::RANK_W'(1));
    send_rank(perm_unrk_pkg::RANK_W'(2));
    drain;

    // largest size, with an alternating bit pattern in range
    write_size(perm_unrk_pkg::SIZE_MAX);
    send_rank('0);
    send_rank(perm_unrk_pkg::RANK_W'(f16 - 1));
    send_rank(perm_unrk_pkg::RANK_W'(f16));
    send_rank('1);
    send_rank(perm_unrk_pkg::RANK_W'(45'h0AAA_AAAA_AAAA));
    drain;

    // sizes below 2 clamp up, above 16 clamp down; register all-zero/all-one
    write_size('0);
    send_rank(perm_unrk_pkg::RANK_W'(1));
    send_rank(perm_unrk_pkg::RANK_W'(2));
    drain;
    write_size(perm_unrk_pkg::SIZE_W'(1));
    send_rank(perm_unrk_pkg::RANK_W'(0));
    drain;
    write_size(perm_unrk_pkg::SIZE_W'(17));
    send_rank(perm_unrk_pkg::RANK_W'(f16 - 1));
    drain;
    write_size('1);
    send_rank(perm_unrk_pkg::RANK_W'(f16));
    send_rank(perm_unrk_pkg::RANK_W'(12345));
    drain;

    // --- random requests, three idling profiles ---
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        // each burst runs at one size; the drain in between is the point
        // where the sender waits for the unit to empty completely
        write_size(pick_size());
        burst = $urandom_range(8, 20);
        for (int i = 0; i < burst; i++) begin
          send_rank(pick_rank());
        end
        sent += burst;
        drain;
      end
    end

    // make sure nothing extra trickles out after the last element
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d rank requests (%0d out of range) into %0d checked results,",
             sb.ranks_noted, sb.ranks_rejected, sb.results_checked);
    $display("over %0d size settings and three back-pressure profiles; %0d mismatches.",
             sizes_written + 1, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ permutation_unrank_unit.f @@
hw/rtl/perm_unrk_pkg.sv
hw/rtl/perm_unrk_div.sv
hw/rtl/permutation_unrank_unit.sv
tb/tb.sv
